// ===== src/ttc_pkg.sv =====
// Shared types and constants for the tile tag cache.
// No dependencies; imported by every module of the block.
package ttc_pkg;

  localparam int COORD_W = 16;
  localparam int KEY_W   = 6;
  localparam int AGE_W   = 4;
  localparam int SLOT_W  = 4;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_COMMIT,
    ST_EMIT
  } ttc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // capture request, clear scan
    logic div_step;  // register both tile keys
    logic scan_step; // examine one slot
    logic commit;    // apply miss update, latch evict flag
    logic load_out;  // move result into output register
  } ttc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
    logic scan_last;
  } ttc_status_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? a : a + AGE_W'(1);
  endfunction

endpackage

// ===== src/ttc_ctrl.sv =====
// Sequencing FSM for the tile tag cache: divide, scan, commit, emit.
// Depends on ttc_pkg.
module ttc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  ttc_pkg::ttc_status_t status,
  output ttc_pkg::ttc_cmd_t    cmd
);
  import ttc_pkg::*;

  ttc_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIV;
      ST_DIV:    if (status.div_last) state_next = ST_SCAN;
      ST_SCAN:   if (status.scan_last) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_EMIT;
      ST_EMIT:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_COMMIT: cmd.commit    = 1'b1;
      ST_EMIT:   cmd.load_out  = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/ttc_dp.sv =====
// Datapath: reciprocal-multiply tile key, slot tag/age/valid store, scan and output register.
// Depends on ttc_pkg.
module ttc_dp #(
  parameter int WAYS        = 12,
  parameter int TILE_WIDTH  = 1250,
  parameter int TILE_HEIGHT = 1250
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ttc_pkg::COORD_W-1:0]   point_col,
  input  logic [ttc_pkg::COORD_W-1:0]   point_row,
  input  ttc_pkg::ttc_cmd_t             cmd,
  output ttc_pkg::ttc_status_t          status,
  output logic                          hit,
  output logic [ttc_pkg::SLOT_W-1:0]    slot,
  output logic [ttc_pkg::KEY_W-1:0]     tile_col,
  output logic [ttc_pkg::KEY_W-1:0]     tile_row,
  output logic                          evicted
);
  import ttc_pkg::*;

  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PROD_W = 2 * COORD_W + 1;
  // floor(p / d) == (p * ceil(2^s / d)) >> s for any 16-bit p, s = 16 + clog2(d)
  localparam int SH_C = COORD_W + $clog2(TILE_WIDTH);
  localparam int SH_R = COORD_W + $clog2(TILE_HEIGHT);
  localparam logic [COORD_W:0] MUL_C =
    (COORD_W+1)'(((64'd1 << SH_C) + 64'(TILE_WIDTH) - 64'd1) / 64'(TILE_WIDTH));
  localparam logic [COORD_W:0] MUL_R =
    (COORD_W+1)'(((64'd1 << SH_R) + 64'(TILE_HEIGHT) - 64'd1) / 64'(TILE_HEIGHT));

  // captured point and the products that give its tile key
  logic [COORD_W-1:0] pt_col, pt_row;
  logic [PROD_W-1:0]  prod_c, prod_r;
  logic [KEY_W-1:0]   key_c, key_r;

  assign prod_c = PROD_W'(pt_col) * PROD_W'(MUL_C);
  assign prod_r = PROD_W'(pt_row) * PROD_W'(MUL_R);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pt_col <= point_col;
      pt_row <= point_row;
    end
    if (cmd.div_step) begin
      key_c <= KEY_W'(prod_c >> SH_C);  // low six bits of the quotient
      key_r <= KEY_W'(prod_r >> SH_R);
    end
  end

  assign status.div_last = 1'b1;

  // slot store
  logic             slot_valid   [WAYS];
  logic [KEY_W-1:0] slot_tag_col [WAYS];
  logic [KEY_W-1:0] slot_tag_row [WAYS];
  logic [AGE_W-1:0] slot_age     [WAYS];

  // scan state
  logic [IDX_W-1:0] idx, hit_idx, best;
  logic [AGE_W-1:0] best_age, age_cand;
  logic             found, match, evict_flag;

  assign match    = slot_valid[idx] && slot_tag_col[idx] == key_c
                    && slot_tag_row[idx] == key_r;
  assign age_cand = age_inc(slot_age[idx]);
  assign status.scan_last = (idx == IDX_W'(WAYS-1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx      <= '0;
      found    <= 1'b0;
      hit_idx  <= '0;
      best     <= '0;
      best_age <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + IDX_W'(1);
      if (!found && match) begin
        found   <= 1'b1;
        hit_idx <= idx;
      end
      if (age_cand > best_age) begin
        best_age <= age_cand;
        best     <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WAYS; k++) begin
        slot_valid[k] <= 1'b0;
        slot_age[k]   <= '0;
      end
    end else if (cmd.commit && !found) begin
      for (int k = 0; k < WAYS; k++) begin
        if (IDX_W'(k) == best) begin
          slot_age[k]   <= '0;
          slot_valid[k] <= 1'b1;
        end else begin
          slot_age[k] <= age_inc(slot_age[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      evict_flag <= !found && slot_valid[best];
      if (!found) begin
        slot_tag_col[best] <= key_c;
        slot_tag_row[best] <= key_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit      <= found;
      slot     <= found ? SLOT_W'(hit_idx) : SLOT_W'(best);
      tile_col <= key_c;
      tile_row <= key_r;
      evicted  <= evict_flag;
    end
  end

endmodule

// ===== src/tile_tag_cache_replacement.sv =====
// Top level of the tile tag cache with first-in first-out replacement.
// Instantiates ttc_ctrl and ttc_dp; depends on ttc_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_stall  | point_col, point_row
//   out      | out_valid / out_stall| hit, slot, tile_col, tile_row, evicted
//
// After acceptance the block takes no new request until the current one is
// done: the tile key is formed by a reciprocal multiply, the WAYS slots are
// scanned one slot per cycle, then come commit, emit and the return to idle.
// The result is loaded into the output register in the emit step.
// Reset (rst, synchronous) clears all valid bits and ages.
// A result held under out_stall does not block the next request; the block
// waits in its emit step only if the previous result is still unclaimed.
module tile_tag_cache_replacement #(
  parameter int WAYS        = 12,
  parameter int TILE_WIDTH  = 1250,
  parameter int TILE_HEIGHT = 1250
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ttc_pkg::COORD_W-1:0]  point_col,
  input  logic [ttc_pkg::COORD_W-1:0]  point_row,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic [ttc_pkg::SLOT_W-1:0]   slot,
  output logic [ttc_pkg::KEY_W-1:0]    tile_col,
  output logic [ttc_pkg::KEY_W-1:0]    tile_row,
  output logic                         evicted
);
  import ttc_pkg::*;

  ttc_cmd_t    cmd;
  ttc_status_t status;

  // sequencer: owns the handshakes and the output valid flag
  ttc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // key multipliers, slot store, scan and result register
  ttc_dp #(
    .WAYS        (WAYS),
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .point_col (point_col),
    .point_row (point_row),
    .cmd       (cmd),
    .status    (status),
    .hit       (hit),
    .slot      (slot),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .evicted   (evicted)
  );

endmodule

// ===== src/ttc_checker.sv =====
// Port-level checks for the tile tag cache, bound to the top level.
// Depends on ttc_pkg.
module ttc_checker #(
  parameter int WAYS = 12
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         hit,
  input logic [ttc_pkg::SLOT_W-1:0]   slot,
  input logic [ttc_pkg::KEY_W-1:0]    tile_col,
  input logic [ttc_pkg::KEY_W-1:0]    tile_row,
  input logic                         evicted
);
  import ttc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({hit, slot, tile_col, tile_row, evicted}))
    else $error("result changed while stalled");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted)
    else $error("hit reported an eviction");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (WAYS > 16) || (int'(slot) < WAYS))
    else $error("slot out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken while previous one in flight");

endmodule

bind tile_tag_cache_replacement ttc_checker #(.WAYS(WAYS)) u_ttc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .slot      (slot),
  .tile_col  (tile_col),
  .tile_row  (tile_row),
  .evicted   (evicted)
);

// ===== verif/tile_tag_cache_replacement_test.sv =====
// Self-checking bench for tile_tag_cache_replacement: tile key lookup, hit
// reporting and first-in first-out slot replacement. Depends on ttc_pkg and
// the RTL top; built-in predictor, queue-fed driver, clocked monitor.
module tile_tag_cache_replacement_test;
  import ttc_pkg::*;

  // Must track the block's default parameters
  localparam int WAYS        = 12;
  localparam int TILE_WIDTH  = 1250;
  localparam int TILE_HEIGHT = 1250;
  localparam int TOP_TILE    = 65535 / TILE_WIDTH;  // last tile column/row reachable

  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    bit                 drain;  // hold this request until all results are back
  } point_req_t;

  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  tile_col;
    logic [KEY_W-1:0]  tile_row;
    logic              evicted;
  } lookup_result_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] point_col = '0;
  logic [COORD_W-1:0] point_row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic [KEY_W-1:0]   tile_col;
  logic [KEY_W-1:0]   tile_row;
  logic               evicted;

  tile_tag_cache_replacement u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .point_col (point_col),
    .point_row (point_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .slot      (slot),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .evicted   (evicted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the tag store
  logic             tile_held    [WAYS];
  logic [KEY_W-1:0] tile_tag_col [WAYS];
  logic [KEY_W-1:0] tile_tag_row [WAYS];
  logic [AGE_W-1:0] tile_age     [WAYS];

  point_req_t     point_queue[$];       // requests not yet presented
  lookup_result_t expected_lookups[$];  // predicted results, oldest first

  logic in_taken = 1'b0;  // request accepted at the last rising edge
  int   gap_left   = 0;   // idle cycles before the next request
  int   stall_left = 0;   // stall cycles still owed to the current result
  int   in_calm    = 0;   // stretch of requests sent back to back
  int   out_calm   = 0;   // stretch of results taken without stall
  int   error_count = 0;
  int   hit_count   = 0;
  int   miss_count  = 0;
  int   evict_count = 0;
  int   drain_count = 0;

  int hot_col [32];
  int hot_row [32];

  // Tile lookup as the block does it: key compare first, then the aging
  // miss path. Hits leave the store untouched.
  function automatic lookup_result_t predict_lookup(input logic [COORD_W-1:0] col,
                                                    input logic [COORD_W-1:0] row);
    lookup_result_t   res;
    logic [KEY_W-1:0] kc;
    logic [KEY_W-1:0] kr;
    logic [AGE_W-1:0] oldest;
    int               victim;
    bit               found;
    kc      = KEY_W'(int'(col) / TILE_WIDTH);   // wraps to the key width
    kr      = KEY_W'(int'(row) / TILE_HEIGHT);
    found   = 1'b0;
    res.tile_col = kc;
    res.tile_row = kr;
    res.hit      = 1'b0;
    res.slot     = '0;
    res.evicted  = 1'b0;
    for (int k = 0; k < WAYS; k++) begin
      if (!found && tile_held[k] && tile_tag_col[k] == kc && tile_tag_row[k] == kr) begin
        found    = 1'b1;
        res.hit  = 1'b1;
        res.slot = SLOT_W'(k);
      end
    end
    if (!found) begin
      // age everyone (saturating), first slot with the greatest age loses
      oldest = '0;
      victim = 0;
      for (int k = 0; k < WAYS; k++) begin
        if (tile_age[k] != AGE_MAX) tile_age[k] = tile_age[k] + 1'b1;
        if (tile_age[k] > oldest) begin
          oldest = tile_age[k];
          victim = k;
        end
      end
      res.slot     = SLOT_W'(victim);
      res.evicted  = tile_held[victim];
      tile_held[victim]    = 1'b1;
      tile_tag_col[victim] = kc;
      tile_tag_row[victim] = kr;
      tile_age[victim]     = '0;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Random point anywhere inside tile (tc, tr); the last tile is cut short
  // by the 16-bit coordinate range.
  function automatic point_req_t point_in_tile(input int tc, input int tr, input bit drain);
    point_req_t req;
    int         hi_c;
    int         hi_r;
    hi_c = tc * TILE_WIDTH + TILE_WIDTH - 1;
    hi_r = tr * TILE_HEIGHT + TILE_HEIGHT - 1;
    if (hi_c > 65535) hi_c = 65535;
    if (hi_r > 65535) hi_r = 65535;
    req.col   = COORD_W'($urandom_range(tc * TILE_WIDTH, hi_c));
    req.row   = COORD_W'($urandom_range(tr * TILE_HEIGHT, hi_r));
    req.drain = drain;
    return req;
  endfunction

  function automatic point_req_t exact_point(input int col, input int row, input bit drain);
    point_req_t req;
    req.col   = COORD_W'(col);
    req.row   = COORD_W'(row);
    req.drain = drain;
    return req;
  endfunction

  // Driver: changes inputs on the falling edge. A presented request is held
  // until the monitor saw it accepted, then an idle gap is drawn at random,
  // with occasional stretches of back-to-back requests. A request
  // flagged drain waits until every predicted result has come back.
  always @(negedge clk) begin
    point_req_t nxt;
    logic       drive_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      drive_valid = in_valid;
      if (in_valid && in_taken) begin
        drive_valid = 1'b0;
        if (in_calm > 0) begin
          in_calm--;
          gap_left = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          in_calm  = $urandom_range(8, 30);
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 4);
        end
      end
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
          point_col <= COORD_W'($urandom);  // junk while idle
          point_row <= COORD_W'($urandom);
        end else if (point_queue.size() != 0 &&
                     !(point_queue[0].drain && expected_lookups.size() != 0)) begin
          nxt = point_queue.pop_front();
          if (nxt.drain) drain_count++;
          point_col   <= nxt.col;
          point_row   <= nxt.row;
          drive_valid = 1'b1;
        end else begin
          point_col <= COORD_W'($urandom);
          point_row <= COORD_W'($urandom);
        end
      end
      in_valid <= drive_valid;
    end
  end

  // Receiver stall: high while the current result still owes stall cycles;
  // it can already be up when the result appears.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (stall_left > 0);
    end
  end

  // Monitor: predicts on every accepted request, checks every accepted
  // result against the oldest prediction, and draws the next result's stall.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      in_taken   <= 1'b0;
      stall_left = 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        want = predict_lookup(point_col, point_row);
        if (want.hit) hit_count++;
        else miss_count++;
        if (want.evicted) evict_count++;
        expected_lookups.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result, expected none, got hit=%0d slot=%0d tile=(%0d,%0d)",
                   $time, hit, slot, tile_col, tile_row);
          error_count++;
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", int'(want.hit), int'(hit));
          check_field("slot", int'(want.slot), int'(slot));
          check_field("tile_col", int'(want.tile_col), int'(tile_col));
          check_field("tile_row", int'(want.tile_row), int'(tile_row));
          check_field("evicted", int'(want.evicted), int'(evicted));
        end
        if (out_calm > 0) begin
          out_calm--;
          stall_left = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          out_calm   = $urandom_range(8, 30);
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 4);
        end
      end else if (out_valid && out_stall && stall_left > 0) begin
        stall_left--;
      end
    end
  end

  initial begin
    int set_size;
    int pick;
    for (int k = 0; k < WAYS; k++) begin
      tile_held[k]    = 1'b0;
      tile_tag_col[k] = '0;
      tile_tag_row[k] = '0;
      tile_age[k]     = '0;
    end

    // Directed: corner points, tile edges, a full store, then eviction
    // of the oldest slot and re-fetch of an evicted tile.
    point_queue.push_back(exact_point(0, 0, 1'b0));              // cold miss, slot 0
    point_queue.push_back(exact_point(1249, 1249, 1'b0));        // far corner of same tile
    point_queue.push_back(exact_point(65535, 65535, 1'b0));      // top of coordinate range
    point_queue.push_back(exact_point(65000, 65000, 1'b0));      // first point of that tile
    point_queue.push_back(exact_point(1250, 0, 1'b0));           // just past a tile edge
    point_queue.push_back(exact_point(0, 1250, 1'b0));
    point_queue.push_back(exact_point(1250, 1250, 1'b1));        // drain before this one
    for (int k = 0; k < 7; k++)                                  // fill the rest
      point_queue.push_back(point_in_tile(k + 2, k + 2, 1'b0));
    point_queue.push_back(point_in_tile(8, 8, 1'b0));            // hit on the last slot
    point_queue.push_back(exact_point(43690, 21845, 1'b0));      // store full: evicts slot 0
    point_queue.push_back(exact_point(0, 0, 1'b0));              // evicted tile comes back
    point_queue.push_back(exact_point(65535, 0, 1'b0));
    point_queue.push_back(exact_point(32768, 32767, 1'b1));
    point_queue.push_back(exact_point(1249, 1249, 1'b0));        // hit on the refetched tile

    // Random: mostly points in a working set of tiles around the store
    // size, so hits and evictions mix; the rest is arbitrary coordinates.
    set_size = 1;
    for (int n = 0; n < 1100; n++) begin
      if (n % 100 == 0) begin
        set_size = $urandom_range(4, 24);
        for (int k = 0; k < set_size; k++) begin
          hot_col[k] = $urandom_range(0, TOP_TILE);
          hot_row[k] = $urandom_range(0, TOP_TILE);
        end
      end
      if ($urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, set_size - 1);
        point_queue.push_back(point_in_tile(hot_col[pick], hot_row[pick], n % 250 == 125));
      end else begin
        point_queue.push_back(exact_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                                          n % 250 == 125));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (point_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);  // catch any stray result

    $display("Lookups checked: %0d hits, %0d misses (%0d evictions), %0d drain pauses",
             hit_count, miss_count, evict_count, drain_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: more than ten times the slowest legal run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ttc_pkg.sv
src/ttc_ctrl.sv
src/ttc_dp.sv
src/tile_tag_cache_replacement.sv
src/ttc_checker.sv
verif/tile_tag_cache_replacement_test.sv
